>>> rtl/sdcds_pkg.sv
package sdcds_pkg;

    // Field widths of the configuration registers and the item payloads.
    localparam int SPEC_W     = 3;
    localparam int MULT_W     = 9;
    localparam int BASE_W     = 28;
    localparam int PRESET_W   = 16;
    localparam int TARGET_W   = 32;
    localparam int CTRL_W     = 16;
    localparam int ACTUAL_W   = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Datapath widths: the product base*mult, the divider, the divider code,
    // target+1 and the running multiple of target+1.
    localparam int NUM_W  = BASE_W + MULT_W;
    localparam int DIV_W  = 11;
    localparam int CODE_W = 10;
    localparam int T1_W   = TARGET_W + 1;
    localparam int ACC_W  = T1_W + DIV_W;
    localparam int CNT_W  = $clog2(NUM_W + 1);

    // Default search limits.
    localparam int PROG_DIV_MAX_DEF = 1024;
    localparam int V3_DIV_LIMIT_DEF = 2046;
    localparam int V2_DIV_LIMIT_DEF = 256;

    // Fixed constants of the clock-control word, the low-base quirk and the spec version.
    localparam logic [BASE_W-1:0] LOW_BASE_LIMIT = 28'd25000000;
    localparam logic [CTRL_W-1:0] PROG_MODE_BIT  = 16'h0020;
    localparam int                CLKGEN_SEL_POS = 10;
    localparam logic [SPEC_W-1:0] SPEC_V300      = 3'd2;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPEC_VERSION     = 3'd0,
        CFG_USE_PRESET       = 3'd1,
        CFG_CLOCK_MULTIPLIER = 3'd2,
        CFG_DIV_ZERO_QUIRK   = 3'd3,
        CFG_BASE_CLOCK_HZ    = 3'd4,
        CFG_PRESET_WORD      = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [SPEC_W-1:0]   spec_version;
        logic                use_preset;
        logic [MULT_W-1:0]   clock_multiplier;
        logic                div_zero_quirk;
        logic [BASE_W-1:0]   base_clock_hz;
        logic [PRESET_W-1:0] preset_word;
    } t_cfg;

    // Divider selection modes.
    typedef enum logic [1:0] {
        MODE_PROG,
        MODE_EVEN,
        MODE_POW2,
        MODE_PRESET
    } t_mode;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic  load;
        logic  mult;
        logic  start;
        t_mode mode;
        logic  step;
        logic  finish;
        logic  div_step;
        logic  emit;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic done;
        logic fail;
        logic div_last;
    } t_stat;

    // Place a 10-bit divider code into a clock-control word.
    function automatic logic [CTRL_W-1:0] place_divider(
        input logic [CTRL_W-1:0] word,
        input logic [CODE_W-1:0] code
    );
        logic [CTRL_W-1:0] res;
        res = word | {code[7:0], 8'h00} | {8'h00, code[9:8], 6'h00};
        return res;
    endfunction

endpackage

>>> rtl/sdcds_dp.sv
module sdcds_dp #(
    parameter int PROG_DIV_MAX = sdcds_pkg::PROG_DIV_MAX_DEF,
    parameter int V3_DIV_LIMIT = sdcds_pkg::V3_DIV_LIMIT_DEF,
    parameter int V2_DIV_LIMIT = sdcds_pkg::V2_DIV_LIMIT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  sdcds_pkg::t_cfg                 i_cfg,
    input  sdcds_pkg::t_cmd                 i_cmd,
    output sdcds_pkg::t_stat                o_stat,
    input  logic [sdcds_pkg::TARGET_W-1:0]  i_target_clock_hz,
    input  logic [sdcds_pkg::CTRL_W-1:0]    i_current_clock_control,
    output logic [sdcds_pkg::CTRL_W-1:0]    o_clock_control,
    output logic [sdcds_pkg::ACTUAL_W-1:0]  o_actual_clock_hz
);
    import sdcds_pkg::*;

    logic [T1_W-1:0]     r_t1;
    logic [CTRL_W-1:0]   r_cur_ctrl;
    logic [NUM_W-1:0]    r_prod;
    logic [NUM_W-1:0]    r_num;
    logic [ACC_W-1:0]    r_acc;
    logic [DIV_W-1:0]    r_div;
    t_mode               r_mode;
    logic [CTRL_W-1:0]   r_ctrl_word;
    logic [DIV_W-1:0]    r_divisor;
    logic [DIV_W-1:0]    r_rem;
    logic [NUM_W-1:0]    r_quo;
    logic [CNT_W-1:0]    r_cnt;
    logic [CTRL_W-1:0]   r_out_ctrl;
    logic [ACTUAL_W-1:0] r_out_actual;

    logic [ACC_W-1:0]  t1_ext;
    logic              hit;
    logic              is_one;
    logic              lim_prog;
    logic              lim_v3;
    logic              lim_v2;
    logic [DIV_W-1:0]  n_div;
    logic [ACC_W-1:0]  n_acc;
    logic              preset_prog;
    logic [NUM_W-1:0]  num_sel;
    logic [CODE_W-1:0] pcode;
    logic [CODE_W-1:0] f_code;
    logic [CTRL_W-1:0] f_word;
    logic [DIV_W-1:0]  f_divisor;
    logic [DIV_W:0]    shifted;
    logic [DIV_W:0]    diff;
    logic              ge;
    logic [DIV_W-1:0]  n_rem;

    // A divider d meets the target when floor(num/d) <= target,
    // which is num < (target+1)*d; r_acc holds (target+1)*d.
    assign t1_ext   = ACC_W'(r_t1);
    assign hit      = ACC_W'(r_num) < r_acc;
    assign is_one   = r_div == DIV_W'(1);
    assign lim_prog = r_div >= DIV_W'(PROG_DIV_MAX);
    assign lim_v3   = !is_one && (r_div >= DIV_W'(V3_DIV_LIMIT));
    assign lim_v2   = r_div >= DIV_W'(V2_DIV_LIMIT);

    // Search status and next divider for each mode.
    always_comb begin
        o_stat.done     = 1'b0;
        o_stat.fail     = 1'b0;
        o_stat.div_last = r_cnt == CNT_W'(1);
        n_div           = r_div;
        n_acc           = r_acc;
        unique case (r_mode)
            MODE_PROG: begin
                o_stat.done = hit;
                o_stat.fail = !hit && lim_prog;
                n_div       = r_div + DIV_W'(1);
                n_acc       = r_acc + t1_ext;
            end
            MODE_EVEN: begin
                o_stat.done = lim_v3 || hit;
                if (is_one) begin
                    n_div = DIV_W'(2);
                    n_acc = r_acc + t1_ext;
                end else begin
                    n_div = r_div + DIV_W'(2);
                    n_acc = r_acc + {t1_ext[ACC_W-2:0], 1'b0};
                end
            end
            MODE_POW2: begin
                o_stat.done = lim_v2 || hit;
                n_div       = {r_div[DIV_W-2:0], 1'b0};
                n_acc       = {r_acc[ACC_W-2:0], 1'b0};
            end
            MODE_PRESET: begin
                o_stat.done = 1'b1;
            end
        endcase
    end

    // The numerator is the product in programmable mode and for programmable presets, and the base otherwise.
    assign preset_prog = (i_cfg.clock_multiplier != '0) && i_cfg.preset_word[CLKGEN_SEL_POS];
    always_comb begin
        if (i_cmd.mode == MODE_PROG || (i_cmd.mode == MODE_PRESET && preset_prog)) begin
            num_sel = r_prod;
        end else begin
            num_sel = NUM_W'(i_cfg.base_clock_hz);
        end
    end

    // Divider code, control word and real divider once the search is over.
    assign pcode = i_cfg.preset_word[CODE_W-1:0];
    always_comb begin
        f_word    = '0;
        f_code    = r_div[DIV_W-1:1];
        f_divisor = r_div;
        unique case (r_mode)
            MODE_PROG: begin
                f_word = PROG_MODE_BIT;
                f_code = CODE_W'(r_div - DIV_W'(1));
            end
            MODE_EVEN: begin
                if (i_cfg.div_zero_quirk && (f_code == '0)
                        && (i_cfg.base_clock_hz <= LOW_BASE_LIMIT)) begin
                    f_code = CODE_W'(1);
                end
            end
            MODE_POW2: begin
                f_word = '0;
            end
            MODE_PRESET: begin
                f_code = pcode;
                if (preset_prog) begin
                    f_word    = PROG_MODE_BIT;
                    f_divisor = DIV_W'(pcode) + DIV_W'(1);
                end else begin
                    f_word = r_cur_ctrl;
                    if (pcode == '0) begin
                        f_divisor = DIV_W'(1);
                    end else begin
                        f_divisor = {pcode, 1'b0};
                    end
                end
            end
        endcase
    end

    // One restoring division step: shift in a numerator bit, subtract if it fits.
    assign shifted = {r_rem, r_quo[NUM_W-1]};
    assign diff    = shifted - {1'b0, r_divisor};
    assign ge      = shifted >= {1'b0, r_divisor};
    assign n_rem   = ge ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];

    // Datapath registers, each loaded on the controller commands that name it.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_t1       <= T1_W'(i_target_clock_hz) + T1_W'(1);
            r_cur_ctrl <= i_current_clock_control;
        end
        if (i_cmd.mult) begin
            r_prod <= NUM_W'(i_cfg.base_clock_hz) * NUM_W'(i_cfg.clock_multiplier);
        end
        if (i_cmd.start) begin
            r_mode <= i_cmd.mode;
            r_num  <= num_sel;
            r_div  <= DIV_W'(1);
            r_acc  <= t1_ext;
        end
        if (i_cmd.step) begin
            r_div <= n_div;
            r_acc <= n_acc;
        end
        if (i_cmd.finish) begin
            r_ctrl_word <= place_divider(f_word, f_code);
            r_divisor   <= f_divisor;
            r_quo       <= r_num;
            r_rem       <= '0;
            r_cnt       <= CNT_W'(NUM_W);
        end
        if (i_cmd.div_step) begin
            r_quo <= {r_quo[NUM_W-2:0], ge};
            r_rem <= n_rem;
            r_cnt <= r_cnt - CNT_W'(1);
        end
        if (i_cmd.emit) begin
            r_out_ctrl <= r_ctrl_word;
            if (|r_quo[NUM_W-1:ACTUAL_W]) begin
                r_out_actual <= '1;
            end else begin
                r_out_actual <= r_quo[ACTUAL_W-1:0];
            end
        end
    end

    assign o_clock_control   = r_out_ctrl;
    assign o_actual_clock_hz = r_out_actual;

    // The divider is never zero while the division runs.
    a_divisor_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> r_divisor != '0)
        else $error("division step with a zero divisor");

    // The partial remainder stays below the divisor.
    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> r_rem < r_divisor)
        else $error("partial remainder not below divisor");

    // A result is taken only after every division step has run.
    a_emit_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> r_cnt == '0)
        else $error("result taken before the division finished");

endmodule

>>> rtl/sdcds_ctrl.sv
module sdcds_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  sdcds_pkg::t_cfg  i_cfg,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output sdcds_pkg::t_cmd  o_cmd,
    input  sdcds_pkg::t_stat i_stat
);
    import sdcds_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROD,
        ST_SETUP,
        ST_SEARCH,
        ST_DIV,
        ST_DONE
    } t_state;

    t_state r_state;
    logic   r_in_ready;
    logic   r_out_valid;
    t_mode  setup_mode;
    logic   in_accept;

    assign in_accept = i_in_valid && r_in_ready;

    // First search mode for the configured spec version and features.
    always_comb begin
        if (i_cfg.spec_version < SPEC_V300) begin
            setup_mode = MODE_POW2;
        end else if (i_cfg.use_preset) begin
            setup_mode = MODE_PRESET;
        end else if (i_cfg.clock_multiplier != '0) begin
            setup_mode = MODE_PROG;
        end else begin
            setup_mode = MODE_EVEN;
        end
    end

    // Datapath commands for the current state.
    always_comb begin
        o_cmd      = '0;
        o_cmd.mode = setup_mode;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.load = in_accept;
            end
            ST_PROD: begin
                o_cmd.mult = 1'b1;
            end
            ST_SETUP: begin
                o_cmd.start = 1'b1;
            end
            ST_SEARCH: begin
                if (i_stat.fail) begin
                    // Programmable search exhausted: fall back to even dividers.
                    o_cmd.start = 1'b1;
                    o_cmd.mode  = MODE_EVEN;
                end else if (i_stat.done) begin
                    o_cmd.finish = 1'b1;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
            end
            ST_DONE: begin
                o_cmd.emit = !r_out_valid || i_out_ready;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    // State and handshake registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_in_ready  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_accept) begin
                        r_state    <= ST_PROD;
                        r_in_ready <= 1'b0;
                    end
                end
                ST_PROD: begin
                    r_state <= ST_SETUP;
                end
                ST_SETUP: begin
                    r_state <= ST_SEARCH;
                end
                ST_SEARCH: begin
                    if (!i_stat.fail && i_stat.done) begin
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (i_stat.div_last) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (o_cmd.emit) begin
                        r_state    <= ST_IDLE;
                        r_in_ready <= 1'b1;
                    end
                end
                default: begin
                    r_state    <= ST_IDLE;
                    r_in_ready <= 1'b1;
                end
            endcase
        end
    end

    assign o_in_ready  = r_in_ready;
    assign o_out_valid = r_out_valid;

    // An accepted item starts the product stage at once.
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_state == ST_PROD)
        else $error("accepted item did not start processing");

    // A new result appears only out of the final state.
    a_valid_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == ST_DONE)
        else $error("result valid raised outside the final state");

    // The search never advances past a terminating divider.
    a_step_not_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.step |-> !(i_stat.done || i_stat.fail))
        else $error("search stepped past its end");

    // The last division step leads to the final state.
    a_div_to_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && i_stat.div_last) |=> r_state == ST_DONE)
        else $error("division end did not reach the final state");

endmodule

>>> rtl/sd_clock_divider_select_unit.sv
// SD host clock divider selection.
// Input channel (i_in_valid / o_in_ready) takes one item: the requested card
// clock and the present clock-control word. Output channel (o_out_valid /
// i_out_ready) returns one item per input: the clock-control word and the
// resulting card clock, saturated to 32 bits. The configuration channel
// (i_cfg_valid / o_cfg_ready, always ready) writes one register per item by
// index: spec version, preset enable, multiplier, divider-zero quirk, base
// clock, preset word; write it only while no item is in flight.
// Each accepted item runs a divider search, one candidate divider per cycle,
// then a bit-serial division of base*multiplier (programmable mode and
// programmable presets) or of the base (other modes) by the chosen divider.
// The search tries dividers up to PROG_DIV_MAX in programmable mode, then
// even dividers up to V3_DIV_LIMIT in even mode or on a fallback, powers of
// two up to V2_DIV_LIMIT before spec 3.00, and none with presets. One item
// is worked on at a time, and the next is accepted once the result reaches
// the output register.
// Reset restores the configuration registers, idles the sequencer and
// empties the output. A finished result waits in the output register while
// the receiver stalls; the next item is accepted meanwhile, and its result
// waits for that slot.
module sd_clock_divider_select_unit #(
    parameter int PROG_DIV_MAX = sdcds_pkg::PROG_DIV_MAX_DEF,
    parameter int V3_DIV_LIMIT = sdcds_pkg::V3_DIV_LIMIT_DEF,
    parameter int V2_DIV_LIMIT = sdcds_pkg::V2_DIV_LIMIT_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [sdcds_pkg::TARGET_W-1:0]    i_target_clock_hz,
    input  logic [sdcds_pkg::CTRL_W-1:0]      i_current_clock_control,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [sdcds_pkg::CTRL_W-1:0]      o_clock_control,
    output logic [sdcds_pkg::ACTUAL_W-1:0]    o_actual_clock_hz,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [sdcds_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [sdcds_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import sdcds_pkg::*;

    t_cfg  r_cfg;
    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    // Configuration registers; indexes past the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.spec_version     <= SPEC_V300;
            r_cfg.use_preset       <= 1'b0;
            r_cfg.clock_multiplier <= '0;
            r_cfg.div_zero_quirk   <= 1'b0;
            r_cfg.base_clock_hz    <= '0;
            r_cfg.preset_word      <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SPEC_VERSION:     r_cfg.spec_version     <= i_cfg_data[SPEC_W-1:0];
                CFG_USE_PRESET:       r_cfg.use_preset       <= i_cfg_data[0];
                CFG_CLOCK_MULTIPLIER: r_cfg.clock_multiplier <= i_cfg_data[MULT_W-1:0];
                CFG_DIV_ZERO_QUIRK:   r_cfg.div_zero_quirk   <= i_cfg_data[0];
                CFG_BASE_CLOCK_HZ:    r_cfg.base_clock_hz    <= i_cfg_data[BASE_W-1:0];
                CFG_PRESET_WORD:      r_cfg.preset_word      <= i_cfg_data[PRESET_W-1:0];
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    // Sequencer for the search and division.
    sdcds_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    // Divider search, bit-serial division and result registers.
    sdcds_dp #(
        .PROG_DIV_MAX (PROG_DIV_MAX),
        .V3_DIV_LIMIT (V3_DIV_LIMIT),
        .V2_DIV_LIMIT (V2_DIV_LIMIT)
    ) u_dp (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .i_cfg                   (r_cfg),
        .i_cmd                   (cmd),
        .o_stat                  (stat),
        .i_target_clock_hz       (i_target_clock_hz),
        .i_current_clock_control (i_current_clock_control),
        .o_clock_control         (o_clock_control),
        .o_actual_clock_hz       (o_actual_clock_hz)
    );

endmodule
